[rtl/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared widths, reset values, register indexes and the command and status
// structs that join the controller and the datapath of the cache hit counter.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // default geometry bounds
  localparam int INDEX_BITS_MAX_DEF = 14;
  localparam int ADDRESS_BITS_DEF   = 32;

  // fixed field widths
  localparam int TAG_W       = 32;
  localparam int CNT_W       = 32;
  localparam int BSL_W       = 4;
  localparam int CSL_W       = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE_LOG2 = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CACHE_SIZE_LOG2 = 1'b1;

  // register reset values
  localparam logic [BSL_W-1:0] BSL_RESET = 4'd4;
  localparam logic [CSL_W-1:0] CSL_RESET = 5'd12;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // controller to datapath commands
  typedef struct packed {
    logic clear_en;   // write one invalid line of the sweep
    logic lookup_en;  // item accepted: split address, read tag store
    logic update_en;  // compare, fill on miss, count, emit result
  } dmc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last; // sweep is on its last line
  } dmc_stat_t;

endpackage

[rtl/dmc_ctrl.sv]
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer: clears the tag store after reset, then runs each accepted item
// through a registered tag read and then a compare-and-fill step.
// ----------------------------------------------------------------------------
module dmc_ctrl
  import dmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output dmc_cmd_t  cmd,
  input  dmc_stat_t stat
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign busy          = (state_r != ST_IDLE);
  assign cmd.clear_en  = (state_r == ST_CLEAR);
  assign cmd.lookup_en = (state_r == ST_IDLE) && start;
  assign cmd.update_en = (state_r == ST_LOOKUP);

endmodule

[rtl/dmc_datapath.sv]
// ----------------------------------------------------------------------------
// dmc_datapath
// Geometry registers, address split, tag store with valid bits, hit compare,
// saturating counters and the registered result.
// ----------------------------------------------------------------------------
module dmc_datapath
  import dmc_pkg::*;
#(
  parameter int INDEX_BITS_MAX = INDEX_BITS_MAX_DEF,
  parameter int ADDRESS_BITS   = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dmc_cmd_t                cmd,
  output dmc_stat_t               stat,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [ADDRESS_BITS-1:0] in_address,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic [CNT_W-1:0]        out_access_count,
  output logic [CNT_W-1:0]        out_hit_count
);

  localparam int LINES = 1 << INDEX_BITS_MAX;
  localparam int IW_W  = $clog2(INDEX_BITS_MAX + 1);
  localparam int XW    = ADDRESS_BITS + TAG_W;

  // geometry registers
  logic [BSL_W-1:0] bsl_r;
  logic [CSL_W-1:0] csl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsl_r <= BSL_RESET;
      csl_r <= CSL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE_LOG2: bsl_r <= cfg_wdata[BSL_W-1:0];
        REG_CACHE_SIZE_LOG2: csl_r <= cfg_wdata[CSL_W-1:0];
        default: ;
      endcase
    end
  end

  // index width, clamped
  logic [IW_W-1:0] iw;

  always_comb begin
    logic [CSL_W-1:0] diff;
    diff = csl_r - CSL_W'(bsl_r);
    if (csl_r <= CSL_W'(bsl_r)) begin
      iw = '0;
    end else if (diff > CSL_W'(INDEX_BITS_MAX)) begin
      iw = IW_W'(INDEX_BITS_MAX);
    end else begin
      iw = IW_W'(diff);
    end
  end

  // address split
  logic [XW-1:0]             line_addr;
  logic [XW-1:0]             tag_full;
  logic [INDEX_BITS_MAX-1:0] idx_mask;
  logic [INDEX_BITS_MAX-1:0] idx_c;
  logic [TAG_W-1:0]          tag_c;

  assign line_addr = XW'(in_address) >> bsl_r;
  assign tag_full  = line_addr >> iw;
  assign tag_c     = tag_full[TAG_W-1:0];

  always_comb begin
    for (int i = 0; i < INDEX_BITS_MAX; i++) begin
      idx_mask[i] = (IW_W'(i) < iw);
    end
  end

  assign idx_c = line_addr[INDEX_BITS_MAX-1:0] & idx_mask;

  // clearing sweep counter
  logic [INDEX_BITS_MAX-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clear_last = &clr_cnt_r;

  // lookup registers
  logic [INDEX_BITS_MAX-1:0] idx_r;
  logic [TAG_W-1:0]          tag_r;
  logic [TAG_W:0]            rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.lookup_en) begin
      idx_r <= idx_c;
      tag_r <= tag_c;
    end
  end

  // hit compare, valid bit on top of the stored tag
  logic hit_c;
  assign hit_c = rd_data_r[TAG_W] && (rd_data_r[TAG_W-1:0] == tag_r);

  // tag store: one write port, one registered read port
  logic [TAG_W:0] tag_mem [LINES];

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      tag_mem[clr_cnt_r] <= '0;
    end else if (cmd.update_en && !hit_c) begin
      tag_mem[idx_r] <= {1'b1, tag_r};
    end
    if (cmd.lookup_en) begin
      rd_data_r <= tag_mem[idx_c];
    end
  end

  // saturating counters
  logic [CNT_W-1:0] acc_r;
  logic [CNT_W-1:0] hits_r;
  logic [CNT_W-1:0] acc_nxt;
  logic [CNT_W-1:0] hits_nxt;

  assign acc_nxt  = (acc_r == CNT_MAX) ? acc_r : acc_r + 1'b1;
  assign hits_nxt = (hit_c && hits_r != CNT_MAX) ? hits_r + 1'b1 : hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      hits_r <= '0;
    end else if (cmd.update_en) begin
      acc_r  <= acc_nxt;
      hits_r <= hits_nxt;
    end
  end

  // result register
  logic             out_valid_r;
  logic             out_hit_r;
  logic [CNT_W-1:0] out_acc_r;
  logic [CNT_W-1:0] out_hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_en) begin
      out_hit_r  <= hit_c;
      out_acc_r  <= acc_nxt;
      out_hits_r <= hits_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_access_count = out_acc_r;
  assign out_hit_count    = out_hits_r;

endmodule

[rtl/direct_mapped_cache_hit_counter.sv]
// ----------------------------------------------------------------------------
// direct_mapped_cache_hit_counter
// Tag array of a direct-mapped cache with saturating access and hit counts.
// ----------------------------------------------------------------------------
// After reset the block sweeps its tag store to clear every valid bit, one
// line per cycle, and busy stays high for the whole sweep; configuration
// writes are taken during the sweep. An item is then taken when start is
// high and busy low, and busy stays high through its compare-and-fill step,
// so no new item is taken until the last has passed the registered read of
// the tag store and the compare-and-fill step. Each item yields one result,
// shown with out_valid for exactly one cycle from the result register after
// that step; the receiver cannot hold it off. Change the geometry registers
// only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module direct_mapped_cache_hit_counter
  import dmc_pkg::*;
#(
  parameter int INDEX_BITS_MAX = INDEX_BITS_MAX_DEF,
  parameter int ADDRESS_BITS   = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ADDRESS_BITS-1:0] in_address,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic [CNT_W-1:0]        out_access_count,
  output logic [CNT_W-1:0]        out_hit_count,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  dmc_cmd_t  cmd;
  dmc_stat_t stat;

  // sequencer
  dmc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // tag store and counters
  dmc_datapath #(
    .INDEX_BITS_MAX (INDEX_BITS_MAX),
    .ADDRESS_BITS   (ADDRESS_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_access_count (out_access_count),
    .out_hit_count    (out_hit_count)
  );

endmodule

[rtl/dmc_checker.sv]
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks of item timing and counter consistency, bound to the
// top level.
// ----------------------------------------------------------------------------
module dmc_checker
  import dmc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_hit,
  input logic [CNT_W-1:0] out_access_count,
  input logic [CNT_W-1:0] out_hit_count
);

  // an accepted item holds the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted item");

  // every accepted item is followed by its result strobe
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // results are single-cycle strobes, never back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // hits never outnumber accesses
  a_hits_le_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_count <= out_access_count))
    else $error("hit count above access count");

  // a hit result carries a nonzero hit count
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_hit_count != '0))
    else $error("hit reported with zero hit count");

endmodule

bind direct_mapped_cache_hit_counter dmc_checker u_dmc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_hit          (out_hit),
  .out_access_count (out_access_count),
  .out_hit_count    (out_hit_count)
);
